>>> design/epoch_seconds_to_calendar_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-to-calendar converter
// Immediate-consequence and next-cycle property shorthands.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH

`define ESTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar converter check failed");

`define ESTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar converter pipeline check failed");

`endif

>>> design/ests_pkg.sv
// ----------------------------------------------------------------------------
// ests_pkg
// Constants and tables shared by the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ests_pkg;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 40;
  localparam int unsigned DEPTH   = 7;

  localparam logic [31:0] EPOCH_2000   = 32'd946684800;
  localparam logic [31:0] DAY_MAGIC    = 32'd3257812231;
  localparam logic [15:0] HOUR_MAGIC   = 16'd37283;
  localparam logic [12:0] MIN_MAGIC    = 13'd4370;
  localparam logic [15:0] QUAD_MAGIC   = 16'd45934;
  localparam logic [15:0] LEAP_FIX_DAY = 16'd36584;

  typedef logic [15:0] days_t;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    base = 9'd0;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && idx >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

>>> design/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Unix timestamp to calendar fields counted from the year 2000.
// ----------------------------------------------------------------------------
// Fully pipelined: one request enters per cycle while the output is not
// stalled, and its result is offered once it has passed through the seven
// register stages of reciprocal multiplies and compare banks. A stalled
// output holds the whole pipeline.
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // epoch_seconds[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // year_offset[7:0], month_number[11:8],
                                 // day_of_month[16:12], hour_of_day[21:17],
                                 // minute_of_hour[27:22], second_of_minute[33:28]
);

  logic [ests_pkg::DEPTH-1:0] vld;
  logic                       en;
  logic [31:0]                t0;
  ests_pkg::days_t            days;
  logic [7:0]                 year_offset;
  logic [3:0]                 month_number;
  logic [4:0]                 day_of_month;
  logic [4:0]                 hour_of_day;
  logic [5:0]                 minute_of_hour;
  logic [5:0]                 second_of_minute;

  assign en       = !vld[ests_pkg::DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[ests_pkg::DEPTH-1];
  assign m_tdata  = {6'd0, second_of_minute, minute_of_hour, hour_of_day,
                     day_of_month, month_number, year_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ests_pkg::DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= s_tdata - ests_pkg::EPOCH_2000;
    end
  end

  ests_time u_time (
    .clk              (clk),
    .en               (en),
    .t                (t0),
    .days             (days),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  ests_date u_date (
    .clk          (clk),
    .en           (en),
    .days         (days),
    .year_offset  (year_offset),
    .month_number (month_number),
    .day_of_month (day_of_month)
  );

`include "epoch_seconds_to_calendar_top_assert.svh"

  `ESTS_ASSERT_NOW(a_month_range, m_tvalid, (month_number >= 4'd1) && (month_number <= 4'd12))
  `ESTS_ASSERT_NOW(a_hour_range, m_tvalid, hour_of_day < 5'd24)
  `ESTS_ASSERT_NOW(a_time_range, m_tvalid, (minute_of_hour < 6'd60) && (second_of_minute < 6'd60))
  `ESTS_ASSERT_NOW(a_day_range, m_tvalid, (day_of_month != 5'd0) && (year_offset <= 8'd136))
  `ESTS_ASSERT_NEXT(a_advance, en && vld[ests_pkg::DEPTH-2], m_tvalid)

endmodule

>>> design/ests_time.sv
// ----------------------------------------------------------------------------
// ests_time
// Splits the reduced timestamp into day count, hour, minute and second.
// ----------------------------------------------------------------------------
module ests_time (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         t,
  output ests_pkg::days_t     days,
  output logic [4:0]          hour_of_day,
  output logic [5:0]          minute_of_hour,
  output logic [5:0]          second_of_minute
);

  logic [31:0] t1;
  logic [63:0] dprod;
  logic [33:0] dmul;
  logic [16:0] sod2, sod3;
  logic [33:0] hprod;
  logic [4:0]  hr3, hr4, hr5;
  logic [16:0] hmul;
  logic [11:0] r2_4, r2_5;
  logic [24:0] mprod;
  logic [5:0]  min5;
  logic [11:0] smul;

  assign dprod = 64'(t) * 64'(ests_pkg::DAY_MAGIC);
  assign dmul  = 34'(days) * 34'd86400;
  assign hprod = 34'(sod2) * 34'(ests_pkg::HOUR_MAGIC);
  assign hmul  = 17'(hr3) * 17'd3600;
  assign mprod = 25'(r2_4) * 25'(ests_pkg::MIN_MAGIC);
  assign smul  = 12'(min5) * 12'd60;

  always_ff @(posedge clk) begin
    if (en) begin
      t1               <= t;
      days             <= dprod[63:48];
      sod2             <= t1[16:0] - dmul[16:0];
      hr3              <= hprod[31:27];
      sod3             <= sod2;
      r2_4             <= 12'(sod3 - hmul);
      hr4              <= hr3;
      min5             <= mprod[23:18];
      r2_5             <= r2_4;
      hr5              <= hr4;
      second_of_minute <= 6'(r2_5 - smul);
      minute_of_hour   <= min5;
      hour_of_day      <= hr5;
    end
  end

endmodule

>>> design/ests_date.sv
// ----------------------------------------------------------------------------
// ests_date
// Turns a day count from 2000-01-01 into year offset, month and day.
// ----------------------------------------------------------------------------
module ests_date (
  input  logic                clk,
  input  logic                en,
  input  ests_pkg::days_t     days,
  output logic [7:0]          year_offset,
  output logic [3:0]          month_number,
  output logic [4:0]          day_of_month
);

  logic [15:0] adj2, adj3;
  logic [31:0] qprod;
  logic [5:0]  q3, q4;
  logic [15:0] qmul;
  logic [10:0] r4;
  logic [1:0]  yin;
  logic [10:0] dsub;
  logic [8:0]  d5;
  logic        leap5;
  logic [7:0]  year5;
  logic [3:0]  idx;
  logic [8:0]  dstart;

  assign qprod = 32'(adj2) * 32'(ests_pkg::QUAD_MAGIC);
  assign qmul  = 16'(q3) * 16'd1461;

  always_comb begin
    if (r4 >= 11'd1096) begin
      yin  = 2'd3;
      dsub = r4 - 11'd1096;
    end else if (r4 >= 11'd731) begin
      yin  = 2'd2;
      dsub = r4 - 11'd731;
    end else if (r4 >= 11'd366) begin
      yin  = 2'd1;
      dsub = r4 - 11'd366;
    end else begin
      yin  = 2'd0;
      dsub = r4;
    end
  end

  always_comb begin
    idx = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (d5 >= ests_pkg::month_start(leap5, 4'(k))) begin
        idx = 4'(k);
      end
    end
    dstart = ests_pkg::month_start(leap5, idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adj2         <= days + ((days >= ests_pkg::LEAP_FIX_DAY) ? 16'd1 : 16'd0);
      adj3         <= adj2;
      q3           <= qprod[31:26];
      r4           <= 11'(adj3 - qmul);
      q4           <= q3;
      year5        <= {q4, 2'b00} + 8'(yin);
      leap5        <= (yin == 2'd0);
      d5           <= dsub[8:0];
      year_offset  <= year5;
      month_number <= idx + 4'd1;
      day_of_month <= 5'(d5 - dstart + 9'd1);
    end
  end

endmodule
